[src/modbus_rtu_holding_register_slave_assert.svh]
// Assertion macros for the Modbus RTU holding register slave.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MODBUS_RTU_HOLDING_REGISTER_SLAVE_ASSERT_SVH
`define MODBUS_RTU_HOLDING_REGISTER_SLAVE_ASSERT_SVH

// Consequent checked in the same cycle.
`define MBRTU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbrtu assertion failed");

// Consequent checked in the next cycle.
`define MBRTU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbrtu assertion failed");

`endif

[src/mbrtu_pkg.sv]
// Shared types and constants of the Modbus RTU holding register slave.
// No dependencies.
package mbrtu_pkg;

    localparam int REG_DEPTH_DEF = 128;
    localparam int MAX_READ_DEF  = 29;
    localparam int RX_LIMIT_DEF  = 2047;

    localparam int RX_COUNT_W  = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int REG_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS  = 1'd1;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] FC_WRITE = 8'h06;
    localparam logic [7:0] EXC_FLAG = 8'h80;

    localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0] EXC_CRC          = 8'h04;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_byte;
        logic        rx_error;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } rsp_t;

endpackage

[src/mbrtu_if.sv]
// Request and response channel interfaces (valid/ready with payload).
// Depends on mbrtu_pkg.
interface mbrtu_req_if;
    import mbrtu_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mbrtu_rsp_if;
    import mbrtu_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/modbus_rtu_holding_register_slave.sv]
// Modbus RTU slave answering functions 03 and 06 on a holding register store.
// Depends on mbrtu_pkg, mbrtu_if, mbrtu_ram, mbrtu_crc and the assertion header.
//
// Channels: req carries received bytes, idle ticks and local register writes;
// rsp carries reply bytes in wire order, last set on the CRC high byte.
// Configuration (slave address, gap ticks) is written on cfg_we/cfg_index/cfg_data.
// After reset a clearing pass zeroes the register store with req.ready low;
// configuration writes are taken during it.
// From the third byte of a frame on, a received byte also waits in S_RXCRC
// while the bit-serial CRC unit folds the oldest tail byte. At frame end
// S_CHECK checks the frame, then each reply body byte is loaded (S_EMIT) and
// fed through the CRC unit (S_FEED), each CRC byte is only loaded, and each
// register word first takes a RAM read (S_RD, S_RDW).
// A reply has 5 to 63 bytes.
// The output register frees the sender: new requests are taken while the last
// reply byte waits. A stalled receiver holds the reply sequencer at the next byte.
`include "modbus_rtu_holding_register_slave_assert.svh"

module modbus_rtu_holding_register_slave #(
    parameter int REG_DEPTH = mbrtu_pkg::REG_DEPTH_DEF,
    parameter int MAX_READ  = mbrtu_pkg::MAX_READ_DEF,
    parameter int RX_LIMIT  = mbrtu_pkg::RX_LIMIT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mbrtu_req_if.sink                        req,
    mbrtu_rsp_if.source                      rsp,
    input  logic                             cfg_we,
    input  logic [mbrtu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbrtu_pkg::*;

    localparam int AW = $clog2(REG_DEPTH);
    localparam int CW = 12;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RXCRC, S_CHECK, S_EMIT, S_FEED, S_RD, S_RDW
    } state_t;

    typedef enum logic [1:0] {K_EXC, K_WRITE, K_READ} kind_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [7:0]            slave_reg, slave_next;
    logic [15:0]           gap_reg, gap_next;
    logic [RX_COUNT_W-1:0] rx_count_reg, rx_count_next;
    logic [7:0]            hdr_reg [6];
    logic [7:0]            hdr_next [6];
    logic [7:0]            tail_reg [2];
    logic [7:0]            tail_next [2];
    logic [15:0]           idle_reg, idle_next;
    logic                  timer_reg, timer_next;
    kind_t                 kind_reg, kind_next;
    logic [7:0]            exc_reg, exc_next;
    logic [5:0]            len_reg, len_next;
    logic [5:0]            pos_reg, pos_next;
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic [15:0]           word_reg, word_next;
    logic                  have_word_reg, have_word_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_reg, out_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [REG_W-1:0]      ram_wdata, ram_rdata;
    logic                  crc_clear, crc_start, crc_busy;
    logic [7:0]            crc_data;
    logic [15:0]           crc_val;
    logic                  frame_clear, out_load;

    logic [7:0]            emit_byte;
    logic                  emit_last, emit_body, need_word;
    logic [5:0]            pos_m3;
    logic [CW-1:0]         idx_w;
    logic [15:0]           start_w, count_w, recv_w, tick_idle;
    logic [16:0]           end_w;

    mbrtu_ram #(.WIDTH(REG_W), .DEPTH(REG_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    mbrtu_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (crc_clear),
        .start (crc_start),
        .data  (crc_data),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign idx_w     = CW'(req.payload.reg_index);
    assign start_w   = {hdr_reg[2], hdr_reg[3]};
    assign count_w   = {hdr_reg[4], hdr_reg[5]};
    assign recv_w    = {tail_reg[1], tail_reg[0]};
    assign end_w     = 17'(start_w) + 17'(count_w);
    assign tick_idle = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign pos_m3    = pos_reg - 6'd3;

    always_comb
    begin
        emit_byte = '0;
        emit_last = 1'b0;
        emit_body = (pos_reg < len_reg);
        need_word = (kind_reg == K_READ) && (pos_reg >= 6'd3) && emit_body
                    && !pos_m3[0] && !have_word_reg;
        if (pos_reg == len_reg)
        begin
            emit_byte = crc_val[7:0];
        end
        else if (pos_reg == len_reg + 6'd1)
        begin
            emit_byte = crc_val[15:8];
            emit_last = 1'b1;
        end
        else
        begin
            unique case (kind_reg)
                K_EXC:
                begin
                    if (pos_reg == 6'd0)
                        emit_byte = hdr_reg[0];
                    else if (pos_reg == 6'd1)
                        emit_byte = hdr_reg[1] | EXC_FLAG;
                    else
                        emit_byte = exc_reg;
                end
                K_WRITE:
                begin
                    if (pos_reg == 6'd0)
                        emit_byte = slave_reg;
                    else if (pos_reg == 6'd1)
                        emit_byte = FC_WRITE;
                    else
                        emit_byte = hdr_reg[pos_reg[2:0]];
                end
                K_READ:
                begin
                    if (pos_reg == 6'd0)
                        emit_byte = slave_reg;
                    else if (pos_reg == 6'd1)
                        emit_byte = FC_READ;
                    else if (pos_reg == 6'd2)
                        emit_byte = {2'b00, len_reg - 6'd3};
                    else if (!pos_m3[0])
                        emit_byte = word_reg[15:8];
                    else
                        emit_byte = word_reg[7:0];
                end
                default:
                begin
                    emit_byte = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        slave_next     = slave_reg;
        gap_next       = gap_reg;
        rx_count_next  = rx_count_reg;
        hdr_next       = hdr_reg;
        tail_next      = tail_reg;
        idle_next      = idle_reg;
        timer_next     = timer_reg;
        kind_next      = kind_reg;
        exc_next       = exc_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        rd_addr_next   = rd_addr_reg;
        word_next      = word_reg;
        have_word_next = have_word_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = clr_addr_reg;
        ram_wdata      = '0;
        crc_clear      = 1'b0;
        crc_start      = 1'b0;
        crc_data       = tail_reg[0];
        frame_clear    = 1'b0;
        out_load       = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDR: slave_next = cfg_data[7:0];
                CFG_GAP_TICKS:  gap_next   = cfg_data;
                default:        gap_next   = gap_reg;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(REG_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.payload.operation)
                        OP_BYTE:
                        begin
                            if (!req.payload.rx_error
                                && rx_count_reg < RX_COUNT_W'(RX_LIMIT))
                            begin
                                if (rx_count_reg < RX_COUNT_W'(6))
                                    hdr_next[rx_count_reg[2:0]] = req.payload.rx_byte;
                                if (rx_count_reg >= RX_COUNT_W'(2))
                                begin
                                    crc_start  = 1'b1;
                                    state_next = S_RXCRC;
                                end
                                tail_next[0]  = tail_reg[1];
                                tail_next[1]  = req.payload.rx_byte;
                                rx_count_next = rx_count_reg + 1'b1;
                                idle_next     = '0;
                                timer_next    = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (timer_reg)
                            begin
                                idle_next = tick_idle;
                                if (tick_idle >= gap_reg)
                                begin
                                    if (rx_count_reg >= RX_COUNT_W'(4)
                                        && hdr_reg[0] == slave_reg)
                                        state_next = S_CHECK;
                                    else
                                        frame_clear = 1'b1;
                                end
                            end
                        end
                        OP_WRITE:
                        begin
                            if (idx_w < CW'(REG_DEPTH))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_w[AW-1:0];
                                ram_wdata = req.payload.reg_value;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RXCRC:
            begin
                if (!crc_busy)
                    state_next = S_IDLE;
            end
            S_CHECK:
            begin
                pos_next       = '0;
                have_word_next = 1'b0;
                rd_addr_next   = start_w[AW-1:0];
                kind_next      = K_EXC;
                len_next       = 6'd3;
                crc_clear      = 1'b1;
                state_next     = S_EMIT;
                if (hdr_reg[1] != FC_READ && hdr_reg[1] != FC_WRITE)
                    exc_next = EXC_ILLEGAL_FUNC;
                else if (start_w >= 16'(REG_DEPTH))
                    exc_next = EXC_ILLEGAL_ADDR;
                else if (crc_val != recv_w)
                    exc_next = EXC_CRC;
                else if (hdr_reg[1] == FC_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = start_w[AW-1:0];
                    ram_wdata = count_w;
                    kind_next = K_WRITE;
                    len_next  = 6'd6;
                end
                else if (count_w == 16'd0 || count_w > 16'(MAX_READ)
                         || end_w > 17'(REG_DEPTH))
                    exc_next = EXC_ILLEGAL_ADDR;
                else
                begin
                    kind_next = K_READ;
                    len_next  = 6'd3 + {count_w[4:0], 1'b0};
                end
            end
            S_EMIT:
            begin
                if (need_word)
                    state_next = S_RD;
                else if (!out_valid_reg || rsp.ready)
                begin
                    out_load          = 1'b1;
                    out_valid_next    = 1'b1;
                    out_next.tx_byte  = emit_byte;
                    out_next.last     = emit_last;
                    if (emit_body)
                    begin
                        crc_start  = 1'b1;
                        crc_data   = emit_byte;
                        state_next = S_FEED;
                        if (kind_reg == K_READ && pos_reg >= 6'd3 && pos_m3[0])
                            have_word_next = 1'b0;
                    end
                    else if (emit_last)
                    begin
                        frame_clear = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                        pos_next = pos_reg + 6'd1;
                end
            end
            S_FEED:
            begin
                if (!crc_busy)
                begin
                    pos_next   = pos_reg + 6'd1;
                    state_next = S_EMIT;
                end
            end
            S_RD:
            begin
                ram_re       = 1'b1;
                rd_addr_next = rd_addr_reg + 1'b1;
                state_next   = S_RDW;
            end
            S_RDW:
            begin
                word_next      = ram_rdata;
                have_word_next = 1'b1;
                state_next     = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (frame_clear)
        begin
            rx_count_next = '0;
            hdr_next      = '{default: '0};
            tail_next     = '{default: '0};
            idle_next     = '0;
            timer_next    = 1'b0;
            crc_clear     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            slave_reg     <= 8'd1;
            gap_reg       <= 16'd50;
            rx_count_reg  <= '0;
            hdr_reg       <= '{default: '0};
            tail_reg      <= '{default: '0};
            idle_reg      <= '0;
            timer_reg     <= 1'b0;
            kind_reg      <= K_EXC;
            pos_reg       <= '0;
            len_reg       <= 6'd3;
            have_word_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            slave_reg     <= slave_next;
            gap_reg       <= gap_next;
            rx_count_reg  <= rx_count_next;
            hdr_reg       <= hdr_next;
            tail_reg      <= tail_next;
            idle_reg      <= idle_next;
            timer_reg     <= timer_next;
            kind_reg      <= kind_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            have_word_reg <= have_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exc_reg     <= exc_next;
        rd_addr_reg <= rd_addr_next;
        word_reg    <= word_next;
        out_reg     <= out_next;
    end

    `MBRTU_ASSERT_SAME(a_crc_blocks_req, crc_busy, !req.ready)
    `MBRTU_ASSERT_SAME(a_rx_count_bound, 1'b1, rx_count_reg <= RX_COUNT_W'(RX_LIMIT))
    `MBRTU_ASSERT_SAME(a_pos_bound, state_reg == S_EMIT, pos_reg <= len_reg + 6'd1)
    `MBRTU_ASSERT_NEXT(a_last_closes, out_load && emit_last, rx_count_reg == '0 && !timer_reg)

endmodule

[src/mbrtu_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
module mbrtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[src/mbrtu_crc.sv]
// Bit-serial CRC-16/MODBUS unit, one bit per cycle while busy is high.
// Depends on mbrtu_pkg.
module mbrtu_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        start,
    input  logic [7:0]  data,
    output logic [15:0] crc,
    output logic        busy
);
    import mbrtu_pkg::*;

    logic [15:0] crc_reg;
    logic [7:0]  sh_reg;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    logic        fb;

    assign fb   = crc_reg[0] ^ sh_reg[0];
    assign crc  = crc_reg;
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            sh_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (clear)
        begin
            crc_reg  <= CRC_INIT;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            sh_reg   <= data;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            crc_reg  <= {1'b0, crc_reg[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
            sh_reg   <= {1'b0, sh_reg[7:1]};
            cnt_reg  <= cnt_reg + 3'd1;
            busy_reg <= (cnt_reg != 3'd7);
        end
    end
endmodule
